// ----- rtl/pip_pkg.sv -----
// Shared types and constants of the point-in-polygon test block.
// Used by pip_edge, point_in_polygon_test and pip_checker; depends on nothing.
package pip_pkg;

  // fixed field widths of the stream items and of the count register
  localparam int IDX_W = 4;
  localparam int CFG_W = 5;
  localparam int CNT_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  // result item: inside flag, then crossing count, padded to whole bytes
  localparam int OUT_W   = ((1 + CNT_W + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - 1 - CNT_W;

  // command carried in tuser
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // control that travels with one edge through the edge pipeline
  typedef struct packed {
    logic vld;   // an edge occupies this stage
    logic last;  // closing edge of the query
  } edge_tag_t;

  // input tdata width: index, x, y packed from bit 0, padded to bytes
  function automatic int tdata_w(int cw);
    return ((IDX_W + 2 * cw + 7) / 8) * 8;
  endfunction

endpackage

// ----- rtl/pip_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the vertex table; no dependencies.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pip_edge.sv -----
// Edge crossing pipeline: differences, cross products, signed compare.
// Three register stages; depends on pip_pkg.
module pip_edge import pip_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  edge_tag_t                     tag_i,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output edge_tag_t                     tag_o,
  output logic                          cross_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  edge_tag_t tag1_q, tag2_q, tag3_q;

  logic signed [DW-1:0] dxp_d, dy_d, dxb_d, dyp_d;
  logic signed [DW-1:0] dxp_q, dy_q, dxb_q, dyp_q;
  logic                 strad_d, pos_d, strad1_q, pos1_q;
  logic signed [PW-1:0] lhs_d, rhs_d, lhs_q, rhs_q;
  logic                 strad2_q, pos2_q;
  logic                 cross_d, cross_q;

  // stage 1: straddle test and coordinate differences
  always_comb begin
    dxp_d   = $signed({px_i[CW-1], px_i}) - $signed({ax_i[CW-1], ax_i});
    dy_d    = $signed({by_i[CW-1], by_i}) - $signed({ay_i[CW-1], ay_i});
    dxb_d   = $signed({bx_i[CW-1], bx_i}) - $signed({ax_i[CW-1], ax_i});
    dyp_d   = $signed({py_i[CW-1], py_i}) - $signed({ay_i[CW-1], ay_i});
    strad_d = (ay_i > py_i) != (by_i > py_i);
    pos_d   = by_i > ay_i;
  end

  // stage 2: the two cross products
  always_comb begin
    lhs_d = dxp_q * dy_q;
    rhs_d = dxb_q * dyp_q;
  end

  // stage 3: point left of the intersection, compare flipped for falling edges
  always_comb begin
    cross_d = strad2_q && (pos2_q ? (lhs_q < rhs_q) : (rhs_q < lhs_q));
  end

  // control tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  // data path
  always_ff @(posedge clk_i) begin
    dxp_q    <= dxp_d;
    dy_q     <= dy_d;
    dxb_q    <= dxb_d;
    dyp_q    <= dyp_d;
    strad1_q <= strad_d;
    pos1_q   <= pos_d;
    lhs_q    <= lhs_d;
    rhs_q    <= rhs_d;
    strad2_q <= strad1_q;
    pos2_q   <= pos1_q;
    cross_q  <= cross_d;
  end

  assign tag_o   = tag3_q;
  assign cross_o = cross_q;

endmodule

// ----- rtl/point_in_polygon_test.sv -----
// Top level of the even-odd point-in-polygon test: vertex RAM, read sequencer,
// crossing accumulator and result register. Depends on pip_pkg, pip_ram, pip_edge.
//
//  channel    | direction | payload
//  -----------+-----------+--------------------------------------------------
//  s_axis     | in        | tuser command; tdata index, x, y
//  m_axis     | out       | tdata inside flag, crossing count
//  cfg        | in        | vertex count register
//
// A load writes the RAM when it is taken, if its index lies within the table. In
// a query with n vertices in use, the single RAM read port walks n + 1 vertices
// (the first one again to close the polygon), then the edges pass the edge
// stages and the handoff. A query with no vertices reads none and yields count 0.
// No item is taken while a query runs. A waiting result does not block a load
// or the next query; a query finishing into a full result register waits there.
// Reset sets the count register to 4 and leaves the RAM undefined.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: vertex_index, coord_x, coord_y from bit 0, zero padded
  input  logic [tdata_w(COORD_WIDTH)-1:0]     s_axis_tdata,
  // tuser: command
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: inside_res, crossing_count from bit 0, zero padded
  output logic [OUT_W-1:0]                    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [CFG_W-1:0]                    cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int MVW  = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (MVW > CFG_W) ? MVW : CFG_W;
  localparam int IXW  = (MVW > IDX_W) ? MVW : IDX_W;

  // input item fields
  cmd_e                 cmd;
  logic [IDX_W-1:0]     in_idx;
  logic [CW-1:0]        in_x, in_y;
  logic                 in_acc, load_acc, query_acc, slot_ok;

  // configuration
  logic [CFG_W-1:0]     cfg_q;
  logic [MVW-1:0]       n_use;

  // sequencer
  logic                 busy_q, iss_q, pend_q;
  logic [MVW-1:0]       step_q, n_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 rv_q, rfirst_q, rlast_q;
  logic signed [CW-1:0] px_q, py_q;
  logic [2*CW-1:0]      prev_q;
  logic                 step_end;

  // RAM
  logic                 ram_we;
  logic [AW-1:0]        waddr, raddr;
  logic [AW+IDX_W-1:0]  waddr_ext;
  logic [AW+MVW-1:0]    raddr_ext;
  logic [2*CW-1:0]      rdata;

  // edge pipeline
  edge_tag_t            etag_in, etag_out;
  logic                 ecross;

  // result
  logic                 out_vld_q, out_load;
  logic [CNT_W-1:0]     out_cnt_q;

  // unpack and accept
  assign cmd       = cmd_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[IDX_W-1:0];
  assign in_x      = s_axis_tdata[IDX_W +: CW];
  assign in_y      = s_axis_tdata[IDX_W + CW +: CW];
  assign s_axis_tready = !busy_q;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign load_acc  = in_acc && (cmd == CMD_LOAD);
  assign query_acc = in_acc && (cmd == CMD_QUERY);
  assign slot_ok   = IXW'(in_idx) < IXW'(MAX_VERTICES);

  // count register, clamped to the table depth
  assign cfg_ready_o = 1'b1;
  assign n_use = (CMPW'(cfg_q) > CMPW'(MAX_VERTICES)) ? MVW'(MAX_VERTICES) : MVW'(cfg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  // RAM addressing: writes from loads, reads walk 0..n-1 then 0 again
  assign step_end  = (step_q == n_q);
  assign waddr_ext = {{AW{1'b0}}, in_idx};
  assign waddr     = waddr_ext[AW-1:0];
  assign raddr_ext = {{AW{1'b0}}, (step_end ? MVW'(0) : step_q)};
  assign raddr     = raddr_ext[AW-1:0];
  assign ram_we    = load_acc && slot_ok;

  pip_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({in_y, in_x}),
    .re_i    (iss_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // edge from the previous vertex to the one just read
  assign etag_in.vld  = rv_q && !rfirst_q;
  assign etag_in.last = rlast_q;

  pip_edge #(
    .COORD_WIDTH (CW)
  ) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (etag_in),
    .ax_i    (prev_q[CW-1:0]),
    .ay_i    (prev_q[2*CW-1:CW]),
    .bx_i    (rdata[CW-1:0]),
    .by_i    (rdata[2*CW-1:CW]),
    .px_i    (px_q),
    .py_i    (py_q),
    .tag_o   (etag_out),
    .cross_o (ecross)
  );

  // result moves to the output register once that is free
  assign out_load = pend_q && (!out_vld_q || m_axis_tready);

  // sequencer and accumulator control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      iss_q     <= 1'b0;
      pend_q    <= 1'b0;
      step_q    <= '0;
      n_q       <= '0;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      rfirst_q  <= 1'b0;
      rlast_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rv_q     <= iss_q;
      rfirst_q <= (step_q == '0);
      rlast_q  <= step_end;
      if (query_acc) begin
        busy_q <= 1'b1;
        step_q <= '0;
        n_q    <= n_use;
        cnt_q  <= '0;
        // no vertices: no edges, the result is ready at once
        iss_q  <= (n_use != '0);
        pend_q <= (n_use == '0);
      end else begin
        if (iss_q) begin
          step_q <= step_q + MVW'(1);
          if (step_end) begin
            iss_q <= 1'b0;
          end
        end
        if (etag_out.vld) begin
          cnt_q <= cnt_q + CNT_W'(ecross);
          if (etag_out.last) begin
            pend_q <= 1'b1;
          end
        end
        if (out_load) begin
          pend_q <= 1'b0;
          busy_q <= 1'b0;
        end
      end
      out_vld_q <= out_load || (out_vld_q && !m_axis_tready);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      px_q <= in_x;
      py_q <= in_y;
    end
    if (rv_q) begin
      prev_q <= rdata;
    end
    if (out_load) begin
      out_cnt_q <= cnt_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_cnt_q, out_cnt_q[0]};

endmodule

// ----- rtl/pip_checker.sv -----
// Port-level checks of point_in_polygon_test and the bind that attaches them.
// Depends on pip_pkg and the top level's port list.
module pip_checker import pip_pkg::*; #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic [tdata_w(COORD_WIDTH)-1:0] s_axis_tdata,
  input logic                            s_axis_tuser,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [OUT_W-1:0]                m_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [CFG_W-1:0]                cfg_data_i,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // inside flag is the parity of the count, and the padding is zero
  a_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[1]) && (m_axis_tdata[OUT_W-1:1+CNT_W] == '0))
    else $error("inside flag disagrees with crossing count");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
    else $error("item taken during a query");

  // a load leaves the block free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD) |=> s_axis_tready)
    else $error("load blocked the input");

  // a new result only comes out of a running query
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a query");

endmodule

bind point_in_polygon_test pip_checker #(
  .MAX_VERTICES (MAX_VERTICES),
  .COORD_WIDTH  (COORD_WIDTH)
) u_pip_checker (.*);
